// ----- rtl/coldest_entry_cache_evictor_macros.svh -----
// ---------------------------------------------------------------------------
// Coldest entry cache evictor: assertion macros
// Shared concurrent assertion forms, clocked on clk, off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef COLDEST_ENTRY_CACHE_EVICTOR_MACROS_SVH
`define COLDEST_ENTRY_CACHE_EVICTOR_MACROS_SVH

// same-cycle implication
`define CEEV_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CEEV_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ceev_pkg.sv -----
// ---------------------------------------------------------------------------
// ceev_pkg
// Types, field widths and codes of the coldest entry cache evictor.
// ---------------------------------------------------------------------------
package ceev_pkg;

  localparam int ENTRIES_DEF  = 64;
  localparam int SLOTS_DEF    = 64;
  localparam int HOT_BITS_DEF = 16;
  localparam int MAX_RESULTS  = 64;

  localparam int ENT_FW  = 6;
  localparam int HOT_FW  = 16;
  localparam int TIME_W  = 32;
  localparam int SLOT_FW = 6;
  localparam int THR_W   = 7;
  localparam int CFG_W   = 7;

  localparam logic [CFG_W-1:0] ACT_RESET = 7'd64;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_EVICT = 1'b1;

  localparam logic [1:0] ST_EVICTED  = 2'd0;
  localparam logic [1:0] ST_NONE     = 2'd1;
  localparam logic [1:0] ST_NO_VICT  = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [ENT_FW-1:0]  entry_index;
    logic [HOT_FW-1:0]  hot_value;
    logic [TIME_W-1:0]  stamp_ms;
    logic [SLOT_FW-1:0] cache_slot;
    logic               slot_valid;
    logic               dirty;
    logic [TIME_W-1:0]  now_ms;
    logic [THR_W-1:0]   threshold;
  } in_item_t;

  typedef struct packed {
    logic [ENT_FW-1:0]  victim_idx;
    logic [SLOT_FW-1:0] victim_slot;
    logic               writeback;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

endpackage

// ----- rtl/coldest_entry_cache_evictor.sv -----
// ---------------------------------------------------------------------------
// coldest_entry_cache_evictor
// LFU replacement with aging: ages the directory and frees the coldest slots.
// ---------------------------------------------------------------------------
//  channel | ports                         | handshake
//  --------+-------------------------------+-----------------------------
//  in      | in_valid in_stall in_data     | taken when valid & !stall
//  out     | out_valid out_stall out_data  | taken when valid & !stall
//  cfg     | cfg_valid cfg_ready cfg_data  | written when valid & ready
//
//  A load request is handled in the idle state. An evict request runs the
//  occupancy check, then per victim a pass of a read step, per entry the
//  time delta, aging and compare steps on one shared subtractor, a finish
//  step and an emit step; up to 64 passes. The entry table sits in one RAM
//  with a registered read. Reset is synchronous and needs no clearing pass;
//  a stalled output holds the sequencer in its emit step.
// ---------------------------------------------------------------------------
`include "coldest_entry_cache_evictor_macros.svh"

module coldest_entry_cache_evictor #(
  parameter int ENTRIES  = ceev_pkg::ENTRIES_DEF,
  parameter int SLOTS    = ceev_pkg::SLOTS_DEF,
  parameter int HOT_BITS = ceev_pkg::HOT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ceev_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ceev_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ceev_pkg::CFG_W-1:0] cfg_data
);

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int N_W     = $clog2(ceev_pkg::MAX_RESULTS + 1);
  localparam int TW      = ceev_pkg::TIME_W;
  localparam int SW      = ceev_pkg::SLOT_FW;
  localparam int CW      = ceev_pkg::CFG_W;
  localparam int RAM_W   = SW + TW + HOT_BITS;
  localparam int SUB_W   = TW + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_DIFF  = 8'b0000_1000,
    S_AGE   = 8'b0001_0000,
    S_CMP   = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]               act_r, act_nxt;
  logic [CW-1:0]               cfg_act_r;
  logic [TW-1:0]               now_r, now_nxt;
  logic [ceev_pkg::THR_W-1:0]  thr_r, thr_nxt;
  logic [TW-1:0]               d_r, d_nxt;
  logic [HOT_BITS-1:0]         aged_r, aged_nxt;
  logic [HOT_BITS-1:0]         cold_r, cold_nxt;
  logic [IDX_W-1:0]            victim_r, victim_nxt;
  logic [SW-1:0]               vslot_r, vslot_nxt;
  logic                        found_r, found_nxt;
  logic [N_W-1:0]              n_r, n_nxt;
  ceev_pkg::out_item_t         res_r, res_nxt;
  logic [ENTRIES-1:0]          holds_r, holds_nxt;
  logic [ENTRIES-1:0]          changed_r, changed_nxt;
  logic [SLOTS-1:0]            occ_r, occ_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  ceev_pkg::out_item_t         out_data_r, out_data_nxt;

  // table RAM
  logic                        ram_we, ram_re;
  logic [IDX_W-1:0]            ram_waddr, ram_raddr;
  logic [RAM_W-1:0]            ram_wdata, ram_rdata;
  logic [HOT_BITS-1:0]         rd_hot;
  logic [TW-1:0]               rd_stamp;
  logic [SW-1:0]               rd_slot;

  // shared subtractor
  logic [SUB_W-1:0]            sub_a, sub_b, sub_y;
  logic                        stamp_past;

  logic                        last_idx;
  logic                        ld_entry_ok, ld_slot_ok, v_slot_ok, v_bit;
  logic [CNT_W-1:0]            cnt_after;
  logic                        emit_go;

  assign rd_hot   = ram_rdata[HOT_BITS-1:0];
  assign rd_stamp = ram_rdata[HOT_BITS +: TW];
  assign rd_slot  = ram_rdata[HOT_BITS+TW +: SW];

  // stamp is behind now when now - stamp lies in 1 .. 2^31
  assign stamp_past = (d_r != '0) && (!d_r[TW-1] || (d_r[TW-2:0] == '0));

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state_r)
      S_DIFF: begin
        sub_a = SUB_W'(now_r);
        sub_b = SUB_W'(rd_stamp);
      end
      S_AGE: begin
        sub_a = SUB_W'(rd_hot);
        sub_b = stamp_past ? SUB_W'(d_r >> 1) : SUB_W'(1);
      end
      S_CMP: begin
        sub_a = SUB_W'(cold_r);
        sub_b = SUB_W'(aged_r);
      end
      default: begin
      end
    endcase
  end

  assign sub_y = sub_a - sub_b;

  assign last_idx    = ((CW'(idx_r) + CW'(1)) >= act_r);
  assign ld_entry_ok = ({1'b0, in_data.entry_index} < (ceev_pkg::ENT_FW + 1)'(ENTRIES));
  assign ld_slot_ok  = ({1'b0, in_data.cache_slot} < (SW + 1)'(SLOTS));
  assign v_slot_ok   = ({1'b0, vslot_r} < (SW + 1)'(SLOTS));
  assign v_bit       = v_slot_ok && occ_r[vslot_r[SLOT_AW-1:0]];
  assign cnt_after   = cnt_r - CNT_W'(v_bit);
  assign emit_go     = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    act_nxt       = act_r;
    now_nxt       = now_r;
    thr_nxt       = thr_r;
    d_nxt         = d_r;
    aged_nxt      = aged_r;
    cold_nxt      = cold_r;
    victim_nxt    = victim_r;
    vslot_nxt     = vslot_r;
    found_nxt     = found_r;
    n_nxt         = n_r;
    res_nxt       = res_r;
    holds_nxt     = holds_r;
    changed_nxt   = changed_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = {rd_slot, rd_stamp, aged_r};
    ram_re        = 1'b0;
    ram_raddr     = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.cmd == ceev_pkg::CMD_LOAD) begin
            if (ld_entry_ok) begin
              ram_we    = 1'b1;
              ram_waddr = in_data.entry_index[IDX_W-1:0];
              ram_wdata = {in_data.cache_slot, in_data.stamp_ms,
                           HOT_BITS'(in_data.hot_value)};
              holds_nxt[in_data.entry_index[IDX_W-1:0]]   = in_data.slot_valid;
              changed_nxt[in_data.entry_index[IDX_W-1:0]] = in_data.dirty;
              if (in_data.slot_valid && ld_slot_ok &&
                  !occ_r[in_data.cache_slot[SLOT_AW-1:0]]) begin
                occ_nxt[in_data.cache_slot[SLOT_AW-1:0]] = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
          end else begin
            now_nxt   = in_data.now_ms;
            thr_nxt   = in_data.threshold;
            act_nxt   = (cfg_act_r > CW'(ENTRIES)) ? CW'(ENTRIES) : cfg_act_r;
            n_nxt     = '0;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (ceev_pkg::THR_W'(cnt_r) <= thr_r) begin
          res_nxt   = '{victim_idx: '0, victim_slot: '0, writeback: 1'b0,
                        status: ceev_pkg::ST_NONE, last: 1'b1};
          state_nxt = S_EMIT;
        end else begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (act_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        d_nxt     = sub_y[TW-1:0];
        state_nxt = S_AGE;
      end
      S_AGE: begin
        // borrow means the drop reached below zero
        aged_nxt  = sub_y[SUB_W-1] ? '0 : sub_y[HOT_BITS-1:0];
        state_nxt = S_CMP;
      end
      S_CMP: begin
        ram_we = 1'b1;
        // no borrow: aged <= coldest, later index wins the tie
        if (holds_r[idx_r] && (!found_r || !sub_y[SUB_W-1])) begin
          found_nxt  = 1'b1;
          cold_nxt   = aged_r;
          victim_nxt = idx_r;
          vslot_nxt  = rd_slot;
        end
        if (last_idx) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_r + IDX_W'(1);
          state_nxt = S_DIFF;
        end
      end
      S_FIN: begin
        if (!found_r) begin
          res_nxt = '{victim_idx: '0, victim_slot: '0, writeback: 1'b0,
                      status: ceev_pkg::ST_NO_VICT, last: 1'b1};
        end else begin
          holds_nxt[victim_r] = 1'b0;
          if (v_bit) begin
            occ_nxt[vslot_r[SLOT_AW-1:0]] = 1'b0;
          end
          cnt_nxt = cnt_after;
          res_nxt = '{victim_idx:   ceev_pkg::ENT_FW'(victim_r),
                      victim_slot:  vslot_r,
                      writeback:    changed_r[victim_r],
                      status:       ceev_pkg::ST_EVICTED,
                      last:         (ceev_pkg::THR_W'(cnt_after) <= thr_r) ||
                                    (n_r >= N_W'(ceev_pkg::MAX_RESULTS - 1))};
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          n_nxt         = n_r + N_W'(1);
          if (res_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      found_r     <= 1'b0;
      n_r         <= '0;
      holds_r     <= '0;
      changed_r   <= '0;
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      cfg_act_r   <= ceev_pkg::ACT_RESET;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      n_r         <= n_nxt;
      holds_r     <= holds_nxt;
      changed_r   <= changed_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        cfg_act_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    now_r      <= now_nxt;
    thr_r      <= thr_nxt;
    d_r        <= d_nxt;
    aged_r     <= aged_nxt;
    cold_r     <= cold_nxt;
    victim_r   <= victim_nxt;
    vslot_r    <= vslot_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  ceev_ram #(
    .WIDTH (RAM_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  `CEEV_HOLDS(a_cnt_tracks_occ, 1'b1, cnt_r == CNT_W'($countones(occ_r)), "occupancy count out of step with slot map")
  `CEEV_HOLDS(a_idx_in_range, (state_r == S_DIFF) || (state_r == S_AGE) || (state_r == S_CMP), CW'(idx_r) < act_r, "scan index beyond active entries")
  `CEEV_HOLDS(a_victim_holds, (state_r == S_FIN) && found_r, holds_r[victim_r], "chosen victim holds no slot")
  `CEEV_NEXT(a_emit_lands, (state_r == S_EMIT) && emit_go, out_valid_r && (out_data_r == $past(res_r)), "pending result not handed to output")

endmodule

// ----- rtl/ceev_ram.sv -----
// ---------------------------------------------------------------------------
// ceev_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module ceev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- bench/coldest_entry_cache_evictor_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// coldest_entry_cache_evictor_tb
// Runs directed and random load/evict requests, with random input gaps and
// output stalls, against a cycle-free model of the aging directory. Every
// result is compared field by field with the model's prediction, in order.
// ---------------------------------------------------------------------------
module coldest_entry_cache_evictor_tb;
  import ceev_pkg::*;

  localparam int          DIR_ROWS       = 19;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct {
    in_item_t   req;
    bit         typed;
    logic [1:0] status;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  // directory model
  logic [HOT_FW-1:0]  heat      [64];
  logic [TIME_W-1:0]  touched   [64];
  logic [SLOT_FW-1:0] slot_of   [64];
  bit                 holder    [64];
  bit                 modified  [64];
  logic [63:0]        occ_map;
  logic [CFG_W-1:0]   scan_len;

  out_item_t   victim_q [$];
  out_item_t   fresh    [$];
  int unsigned mismatches;
  int unsigned sent;
  int unsigned quiet_cycles;
  bit          hold_armed;
  logic [TIME_W-1:0] clock_ms;
  dir_row_t    dir_rows [DIR_ROWS];

  coldest_entry_cache_evictor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic in_item_t load_req(logic [ENT_FW-1:0] ent, logic [HOT_FW-1:0] hot,
                                        logic [TIME_W-1:0] st, logic [SLOT_FW-1:0] slot,
                                        logic held, logic dirt);
    in_item_t r;
    r = '0;
    r.cmd = CMD_LOAD;
    r.entry_index = ent;
    r.hot_value = hot;
    r.stamp_ms = st;
    r.cache_slot = slot;
    r.slot_valid = held;
    r.dirty = dirt;
    return r;
  endfunction

  function automatic in_item_t evict_req(logic [TIME_W-1:0] now, logic [THR_W-1:0] thr);
    in_item_t r;
    r = '0;
    r.cmd = CMD_EVICT;
    r.now_ms = now;
    r.threshold = thr;
    return r;
  endfunction

  function automatic int unsigned draw_gap(int unsigned n);
    // every third block of 20 requests runs back to back
    return ((n / 20) % 3 == 1) ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [HOT_FW-1:0] cooled(logic [HOT_FW-1:0] h, logic [TIME_W-1:0] st,
                                               logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] lead;
    logic [TIME_W-1:0] half;
    lead = st - now;
    if (lead[TIME_W-1]) begin
      half = (now - st) >> 1;
      return (TIME_W'(h) > half) ? h - half[HOT_FW-1:0] : '0;
    end
    return (h != '0) ? h - 1'b1 : '0;
  endfunction

  // updates the directory and leaves the request's results in fresh
  task automatic predict_victims(input in_item_t req);
    int unsigned span;
    int unsigned n;
    int          i;
    int          victim;
    bit          found;
    bit          done;
    logic [HOT_FW-1:0] h;
    logic [HOT_FW-1:0] coldest;
    out_item_t   r;
    fresh.delete();
    if (req.cmd == CMD_LOAD) begin
      heat[req.entry_index] = req.hot_value;
      touched[req.entry_index] = req.stamp_ms;
      slot_of[req.entry_index] = req.cache_slot;
      holder[req.entry_index] = req.slot_valid;
      modified[req.entry_index] = req.dirty;
      if (req.slot_valid) occ_map[req.cache_slot] = 1'b1;
      return;
    end
    span = (scan_len > 64) ? 64 : scan_len;
    r = '0;
    if ($countones(occ_map) <= req.threshold) begin
      r.status = ST_NONE;
      r.last = 1'b1;
      fresh.push_back(r);
      return;
    end
    n = 0;
    done = 1'b0;
    while (!done) begin
      found = 1'b0;
      coldest = '0;
      victim = 0;
      for (i = 0; i < span; i++) begin
        h = cooled(heat[i], touched[i], req.now_ms);
        if (holder[i] && (!found || h <= coldest)) begin
          found = 1'b1;
          coldest = h;
          victim = i;
        end
        heat[i] = h;
      end
      r = '0;
      if (!found) begin
        r.status = ST_NO_VICT;
        r.last = 1'b1;
        done = 1'b1;
      end else begin
        occ_map[slot_of[victim]] = 1'b0;
        holder[victim] = 1'b0;
        n++;
        r.victim_idx = ENT_FW'(victim);
        r.victim_slot = slot_of[victim];
        r.writeback = modified[victim];
        r.status = ST_EVICTED;
        r.last = ($countones(occ_map) <= req.threshold) || (n >= MAX_RESULTS);
        done = r.last;
      end
      fresh.push_back(r);
    end
  endtask

  task automatic send_request(input in_item_t req, input bit typed, input logic [1:0] status);
    int unsigned gap;
    out_item_t   r;
    gap = draw_gap(sent);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    sent++;
    predict_victims(req);
    if (typed) begin
      r = '0;
      r.status = status;
      r.last = 1'b1;
      victim_q.push_back(r);
    end else begin
      foreach (fresh[k]) victim_q.push_back(fresh[k]);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (victim_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_scan_len(input logic [CFG_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    scan_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned count);
    logic [127:0] noise;
    in_item_t     req;
    int unsigned  span;
    int unsigned  occ;
    int unsigned  k;
    int unsigned  cut;
    span = (scan_len > 64) ? 64 : scan_len;
    for (k = 0; k < count; k++) begin
      noise = {$urandom(), $urandom(), $urandom(), $urandom()};
      req = noise[$bits(in_item_t)-1:0];
      clock_ms = clock_ms + $urandom_range(0, 300);
      if ($urandom_range(0, 9) < 6) begin
        req.cmd = CMD_LOAD;
        if ($urandom_range(0, 3) != 0) req.entry_index = ENT_FW'($urandom_range(0, span - 1));
        if ($urandom_range(0, 1) != 0) req.hot_value = HOT_FW'($urandom_range(0, 400));
        if ($urandom_range(0, 4) != 0)
          req.stamp_ms = clock_ms + $urandom_range(0, 1000) - 32'd700;
        // a few loads drop the slot bit and leave the slot marked busy
        req.slot_valid = ($urandom_range(0, 6) != 0);
      end else begin
        req.cmd = CMD_EVICT;
        if ($urandom_range(0, 9) != 0) req.now_ms = clock_ms;
        occ = $countones(occ_map);
        cut = $urandom_range(0, 3);
        if ($urandom_range(0, 9) < 7) req.threshold = THR_W'((occ > cut) ? occ - cut : 0);
        else req.threshold = THR_W'($urandom_range(0, 64));
      end
      send_request(req, 1'b0, ST_EVICTED);
    end
  endtask

  // 64 holders sharing one slot plus a slot left busy with no holder:
  // the flush hits the per-request result cap
  task automatic fill_and_flush();
    int unsigned e;
    send_request(evict_req(clock_ms, 7'd0), 1'b0, ST_EVICTED);
    send_request(load_req(6'd0, 16'd0, clock_ms, 6'd50, 1'b1, 1'b0), 1'b0, ST_EVICTED);
    send_request(load_req(6'd0, 16'd0, clock_ms, 6'd50, 1'b0, 1'b0), 1'b0, ST_EVICTED);
    for (e = 0; e < 64; e++)
      send_request(load_req(ENT_FW'(e), HOT_FW'($urandom_range(0, 1000)),
                            clock_ms - $urandom_range(0, 3000),
                            6'd1, 1'b1, 1'($urandom_range(0, 1))), 1'b0, ST_EVICTED);
    send_request(evict_req(clock_ms + 100, 7'd0), 1'b0, ST_EVICTED);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin : result_sink
    int unsigned wait_n;
    int unsigned taken;
    out_item_t   want;
    out_stall = 1'b0;
    taken = 0;
    @(posedge rst_n);
    forever begin
      wait_n = draw_gap(taken + 7);
      if (hold_armed) begin
        hold_armed = 1'b0;
        wait_n = LONG_HOLD;
      end
      @(negedge clk);
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (victim_q.size() == 0) begin
        $error("result with no request pending: %h", out_data);
        mismatches++;
      end else begin
        want = victim_q.pop_front();
        check_field("victim_idx", want.victim_idx, out_data.victim_idx);
        check_field("victim_slot", want.victim_slot, out_data.victim_slot);
        check_field("writeback", want.writeback, out_data.writeback);
        check_field("status", want.status, out_data.status);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    sent = 0;
    quiet_cycles = 0;
    hold_armed = 1'b0;
    clock_ms = '0;
    occ_map = '0;
    scan_len = ACT_RESET;
    for (int i = 0; i < 64; i++) begin
      heat[i] = '0;
      touched[i] = '0;
      slot_of[i] = '0;
      holder[i] = 1'b0;
      modified[i] = 1'b0;
    end

    dir_rows = '{
      '{evict_req(32'h0000_0000, 7'd0),  1'b1, ST_NONE},     // empty cache
      '{evict_req(32'hFFFF_FFFF, 7'd64), 1'b1, ST_NONE},
      '{load_req(6'd7, 16'd5, 32'd0, 6'd9, 1'b1, 1'b0), 1'b0, ST_EVICTED},
      '{load_req(6'd7, 16'd5, 32'd0, 6'd9, 1'b0, 1'b0), 1'b0, ST_EVICTED},
      // slot 9 busy, nobody holds it; stamp equal to now
      '{evict_req(32'h0000_0000, 7'd0),  1'b1, ST_NO_VICT},
      '{load_req(6'd0, 16'hFFFF, 32'h0, 6'd63, 1'b1, 1'b1), 1'b0, ST_EVICTED},
      '{load_req(6'd63, 16'h0, 32'hFFFF_FFFF, 6'd0, 1'b1, 1'b0), 1'b0, ST_EVICTED},
      '{load_req(6'd20, 16'd300, 32'd1000, 6'd20, 1'b1, 1'b1), 1'b0, ST_EVICTED},
      '{load_req(6'd21, 16'd300, 32'd1000, 6'd21, 1'b1, 1'b0), 1'b0, ST_EVICTED},
      '{load_req(6'd30, 16'd40, 32'h8000_0000, 6'd30, 1'b1, 1'b1), 1'b0, ST_EVICTED},
      '{evict_req(32'd1000, 7'd64), 1'b1, ST_NONE},
      '{evict_req(32'h7FFF_FFFF, 7'd5), 1'b0, ST_EVICTED},   // half-window aging, ties
      '{load_req(6'd40, 16'd2, 32'd5, 6'd40, 1'b1, 1'b1), 1'b0, ST_EVICTED},
      '{load_req(6'd41, 16'hAAAA, 32'h5555_5555, 6'd42, 1'b1, 1'b0), 1'b0, ST_EVICTED},
      '{evict_req(32'd6, 7'd3), 1'b0, ST_EVICTED},
      '{evict_req(32'd7, 7'd0), 1'b0, ST_EVICTED},           // drains into no victim
      '{load_req(6'd10, 16'h5555, 32'hAAAA_AAAA, 6'd21, 1'b1, 1'b1), 1'b0, ST_EVICTED},
      '{evict_req(32'hAAAA_AAAA, 7'd64), 1'b1, ST_NONE},
      '{evict_req(32'h5555_5555, 7'd1), 1'b0, ST_EVICTED}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) send_request(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].status);

    set_scan_len(7'd1);
    clock_ms = 32'd5000;
    random_phase(10);

    set_scan_len(7'd64);
    clock_ms = 32'hFFFF_F000;                // time starts close to the wrap point in this phase
    random_phase(5);
    hold_armed = 1'b1;                       // receiver backs off, input must stall
    random_phase(15);

    set_scan_len(7'd100);
    random_phase(8);

    set_scan_len(CFG_W'($urandom_range(2, 63)));
    random_phase(15);

    set_scan_len(7'd64);
    fill_and_flush();

    settle();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && victim_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ceev_pkg.sv
rtl/ceev_ram.sv
rtl/coldest_entry_cache_evictor.sv
bench/coldest_entry_cache_evictor_tb.sv
